### rtl/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg
// Shared constants, request and status codes for the sorted integer set.
// ----------------------------------------------------------------------------
package sis_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 5;
    localparam int IN_DATA_W   = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((STATUS_W + VALUE_WIDTH + COUNT_W + 7) / 8) * 8;

    localparam logic [VALUE_WIDTH-1:0] POP_SENTINEL = VALUE_WIDTH'(64'd999999999);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_POP    = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

endpackage

### rtl/sorted_integer_set.sv
// Insert and delete scan entries one at a time, then move entries one at a time;
// pop reads and removes the top entry unless the set is empty, and clear empties the set.
// A new request is taken the cycle after the output register loads; a held output
// stalls the block in its last state.
// Reset empties the set and the output register; entry contents are kept.
// ----------------------------------------------------------------------------
// sorted_integer_set
// Bounded set of distinct signed integers kept in ascending order in a small memory,
// searched with a less-than and an equality compare and shifted one entry at a time.
// ----------------------------------------------------------------------------
module sorted_integer_set (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // value
    input  logic [sis_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // operation
    input  logic [sis_pkg::OP_W-1:0]          i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // status, popped_value, entry_count
    output logic [sis_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);
    import sis_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SRCH_RD  = 9'b000000010,
        S_SRCH_CMP = 9'b000000100,
        S_DECIDE   = 9'b000001000,
        S_MOVE_RD  = 9'b000010000,
        S_MOVE_WR  = 9'b000100000,
        S_POP_RD   = 9'b001000000,
        S_POP_WR   = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    t_state                         r_state, n_state;
    t_op                            r_op;
    logic signed [VALUE_WIDTH-1:0]  r_value;
    logic signed [VALUE_WIDTH-1:0]  r_rdata;
    logic [CNT_W-1:0]               r_count;
    logic [CNT_W-1:0]               r_idx;
    logic [CNT_W-1:0]               r_pos;
    logic                           r_found;
    t_status                        r_status;
    logic [VALUE_WIDTH-1:0]         r_popped;
    logic                           r_out_valid;
    t_status                        r_out_status;
    logic [VALUE_WIDTH-1:0]         r_out_popped;
    logic [CNT_W-1:0]               r_out_count;

    logic signed [VALUE_WIDTH-1:0]  r_mem [CAPACITY];

    logic                           w_accept;
    logic                           w_out_free;
    logic                           w_less;
    logic                           w_move_done;
    logic [CNT_W-1:0]               w_idx_inc;
    logic [CNT_W-1:0]               w_idx_dec;
    logic [CNT_W-1:0]               w_raddr;
    logic                           w_we;
    logic [CNT_W-1:0]               w_waddr;
    logic signed [VALUE_WIDTH-1:0]  w_wdata;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_less          = (r_rdata < r_value);
    assign w_idx_inc       = r_idx + CNT_W'(1);
    assign w_idx_dec       = r_idx - CNT_W'(1);

    // insert moves entries up from the top, delete moves them down from the hole
    assign w_move_done = (r_op == OP_INSERT) ? (r_idx == r_pos) : (w_idx_inc >= r_count);

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'({COUNT_W'(r_out_count), r_out_popped, r_out_status});

    // memory port control
    always_comb begin
        w_raddr = r_idx;
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = r_rdata;
        unique case (r_state)
            S_MOVE_RD: begin
                w_raddr = (r_op == OP_INSERT) ? w_idx_dec : w_idx_inc;
                if (w_move_done && r_op == OP_INSERT) begin
                    w_we    = 1'b1;
                    w_waddr = r_pos;
                    w_wdata = r_value;
                end
            end
            S_MOVE_WR: begin
                w_we = 1'b1;
            end
            S_POP_RD: begin
                w_raddr = r_count - CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_raddr[IDX_W-1:0]];
        if (w_we) begin
            r_mem[w_waddr[IDX_W-1:0]] <= w_wdata;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (t_op'(i_s_axis_tuser) == OP_INSERT
                        || t_op'(i_s_axis_tuser) == OP_DELETE) begin
                        n_state = S_SRCH_RD;
                    end else begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_SRCH_RD: begin
                n_state = (r_idx == r_count) ? S_DECIDE : S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                n_state = w_less ? S_SRCH_RD : S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_DONE;
                case (r_op)
                    OP_INSERT: if (!r_found && r_count != CNT_W'(CAPACITY)) n_state = S_MOVE_RD;
                    OP_DELETE: if (r_found) n_state = S_MOVE_RD;
                    OP_POP:    if (r_count != '0) n_state = S_POP_RD;
                    default:   n_state = S_DONE;
                endcase
            end
            S_MOVE_RD: begin
                n_state = w_move_done ? S_DONE : S_MOVE_WR;
            end
            S_MOVE_WR: begin
                n_state = S_MOVE_RD;
            end
            S_POP_RD: begin
                n_state = S_POP_WR;
            end
            S_POP_WR: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op     <= t_op'(i_s_axis_tuser);
                        r_value  <= i_s_axis_tdata[VALUE_WIDTH-1:0];
                        r_idx    <= '0;
                        r_found  <= 1'b0;
                        r_status <= ST_DONE;
                        r_popped <= '0;
                    end
                end
                S_SRCH_RD: begin
                    if (r_idx == r_count) begin
                        r_pos   <= r_idx;
                        r_found <= 1'b0;
                    end
                end
                S_SRCH_CMP: begin
                    if (w_less) begin
                        r_idx <= w_idx_inc;
                    end else begin
                        r_pos   <= r_idx;
                        r_found <= (r_rdata == r_value);
                    end
                end
                S_DECIDE: begin
                    case (r_op)
                        OP_INSERT: begin
                            if (r_found) begin
                                r_status <= ST_DUPLICATE;
                            end else if (r_count == CNT_W'(CAPACITY)) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_idx <= r_count;
                            end
                        end
                        OP_DELETE: begin
                            if (!r_found) begin
                                r_status <= ST_NOT_FOUND;
                            end else begin
                                r_idx <= r_pos;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                r_status <= ST_EMPTY;
                                r_popped <= POP_SENTINEL;
                            end
                        end
                        default: begin
                            r_count <= '0;
                        end
                    endcase
                end
                S_MOVE_RD: begin
                    if (w_move_done) begin
                        r_count <= (r_op == OP_INSERT) ? r_count + CNT_W'(1)
                                                       : r_count - CNT_W'(1);
                    end
                end
                S_MOVE_WR: begin
                    r_idx <= (r_op == OP_INSERT) ? w_idx_dec : w_idx_inc;
                end
                S_POP_RD: begin
                end
                S_POP_WR: begin
                    r_popped <= r_rdata;
                    r_count  <= r_count - CNT_W'(1);
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_status <= r_status;
                        r_out_popped <= r_popped;
                        r_out_count  <= r_count;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### verif/tb_sorted_integer_set.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_integer_set
// Drives insert, delete, pop and clear requests into the sorted integer set,
// predicts every response from a queue-based model of the set and checks the
// responses in order under random source idling and sink backpressure.
// ----------------------------------------------------------------------------
module tb_sorted_integer_set;
    import sis_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 10;
    localparam int DRAIN_CYCLES   = 4 * CAPACITY + 8;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int PHASE_ITEMS    = 320;

    localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    typedef struct packed {
        t_status                  status;
        logic [VALUE_WIDTH-1:0]   popped;
        logic [COUNT_W-1:0]       count;
    } t_set_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_s_axis_tvalid = 1'b0;
    logic                     o_s_axis_tready;
    // value
    logic [IN_DATA_W-1:0]     i_s_axis_tdata = '0;
    // operation
    logic [OP_W-1:0]          i_s_axis_tuser = OP_INSERT;
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready = 1'b0;
    // status, popped_value, entry_count
    logic [OUT_DATA_W-1:0]    o_m_axis_tdata;

    logic signed [VALUE_WIDTH-1:0] model_entries[$];
    t_set_result                   pending_results[$];

    int error_count  = 0;
    int cycle_count  = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_trigger = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    sorted_integer_set dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // sink side: random stalls, plus a long hold-off when triggered
    always @(negedge i_clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = RX_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // set model: applies one request and returns the response it produces
    function automatic t_set_result apply_set_request(t_op op,
                                                      logic signed [VALUE_WIDTH-1:0] value);
        t_set_result res;
        int          pos;
        res.status = ST_DONE;
        res.popped = '0;
        pos = 0;
        while (pos < model_entries.size() && model_entries[pos] < value)
            pos++;
        case (op)
            OP_INSERT: begin
                if (pos < model_entries.size() && model_entries[pos] == value)
                    res.status = ST_DUPLICATE;
                else if (model_entries.size() >= CAPACITY)
                    res.status = ST_FULL;
                else
                    model_entries.insert(pos, value);
            end
            OP_DELETE: begin
                if (pos < model_entries.size() && model_entries[pos] == value)
                    model_entries.delete(pos);
                else
                    res.status = ST_NOT_FOUND;
            end
            OP_POP: begin
                if (model_entries.size() == 0) begin
                    res.status = ST_EMPTY;
                    res.popped = POP_SENTINEL;
                end else begin
                    res.popped = model_entries.pop_back();
                end
            end
            default: model_entries.delete();
        endcase
        res.count = COUNT_W'(model_entries.size());
        return res;
    endfunction

    task automatic send_request(t_op op, logic signed [VALUE_WIDTH-1:0] value);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        word[VALUE_WIDTH-1:0] = value;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(apply_set_request(op, value));
    endtask

    // source pauses until every response is back, then lets the block settle
    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // response checker
    always @(posedge i_clk) begin
        t_set_result            want;
        t_status                got_status;
        logic [VALUE_WIDTH-1:0] got_popped;
        logic [COUNT_W-1:0]     got_count;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_status = t_status'(o_m_axis_tdata[STATUS_W-1:0]);
            got_popped = o_m_axis_tdata[STATUS_W +: VALUE_WIDTH];
            got_count  = o_m_axis_tdata[STATUS_W+VALUE_WIDTH +: COUNT_W];
            if (pending_results.size() == 0) begin
                $error("unexpected response: status %0d popped_value %0d entry_count %0d",
                       got_status, $signed(got_popped), got_count);
                error_count = error_count + 1;
            end else begin
                want = pending_results.pop_front();
                if (got_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got_status);
                    error_count = error_count + 1;
                end
                if (got_popped !== want.popped) begin
                    $error("popped_value: expected %0d, actual %0d",
                           $signed(want.popped), $signed(got_popped));
                    error_count = error_count + 1;
                end
                if (got_count !== want.count) begin
                    $error("entry_count: expected %0d, actual %0d", want.count, got_count);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // pop, delete and clear on a set that holds nothing
    task automatic test_empty_set();
        send_request(OP_POP, 32'sd5);
        send_request(OP_DELETE, 32'sd0);
        send_request(OP_CLEAR, VAL_MAX);
        drain_results();
    endtask

    // fill to capacity with the extremes among the values, then hit the limits
    task automatic test_full_set();
        send_request(OP_INSERT, VAL_MAX);
        send_request(OP_INSERT, VAL_MIN);
        send_request(OP_INSERT, 32'sd0);
        send_request(OP_INSERT, -32'sd1);
        for (int k = 1; k <= CAPACITY - 4; k++)
            send_request(OP_INSERT, (k % 2) ? k * 1000 : -k * 1000);
        send_request(OP_INSERT, 32'sd7);
        send_request(OP_INSERT, VAL_MAX);
        send_request(OP_POP, '0);
        send_request(OP_DELETE, VAL_MIN);
        send_request(OP_DELETE, 32'sd12345);
        send_request(OP_CLEAR, '0);
        drain_results();
    endtask

    function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 35 && model_entries.size() != 0)
            return model_entries[$urandom_range(model_entries.size() - 1)];
        else if (sel < 70)
            return $signed($urandom_range(40)) - 20;
        else if (sel < 80) begin
            case ($urandom_range(4))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return -1;
                3: return 1;
                default: return 0;
            endcase
        end
        return $urandom;
    endfunction

    task automatic test_random_traffic(int tx_pct, int rx_pct, int n_items);
        int   sel;
        t_op  op;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (int k = 0; k < n_items; k++) begin
            sel = $urandom_range(99);
            if (sel < 52)      op = OP_INSERT;
            else if (sel < 78) op = OP_DELETE;
            else if (sel < 98) op = OP_POP;
            else               op = OP_CLEAR;
            if (op == OP_INSERT || op == OP_DELETE)
                send_request(op, pick_value());
            else
                send_request(op, $urandom);
        end
        drain_results();
    endtask

    // sink holds off for a long stretch while the source keeps offering
    task automatic test_output_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_trigger = hold_trigger + 1;
        for (int k = 0; k < 40; k++)
            send_request(k % 5 == 4 ? OP_POP : OP_INSERT, pick_value());
        drain_results();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_empty_set();
        test_full_set();
        test_random_traffic(0, 0, PHASE_ITEMS);
        test_output_backpressure();
        test_random_traffic(51, 0, PHASE_ITEMS);
        test_random_traffic(0, 51, PHASE_ITEMS);
        test_random_traffic(37, 37, PHASE_ITEMS);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
